@@ hdl/pmpd_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; imported by every module of the block.
package pmpd_pkg;

    // Header byte bit positions
    localparam int unsigned HDR_SYNC   = 3;
    localparam int unsigned HDR_X_SIGN = 4;
    localparam int unsigned HDR_X_OVER = 5;
    localparam int unsigned HDR_Y_SIGN = 6;
    localparam int unsigned HDR_Y_OVER = 7;

    // Byte position within a packet
    localparam logic [1:0] POS_HDR = 2'd0;
    localparam logic [1:0] POS_X   = 2'd1;
    localparam logic [1:0] POS_Y   = 2'd2;

    // Event codes
    localparam logic       EV_BUTTON  = 1'b0;
    localparam logic       EV_MOTION  = 1'b1;
    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;
    localparam logic [1:0] BTN_NONE   = 2'd3;

    // Packet queue geometry
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Decoded packet handed from front to back
    typedef struct packed {
        logic [2:0]        held;    // button state before this packet
        logic [2:0]        newb;    // button state reported by this packet
        logic signed [8:0] mx;
        logic signed [8:0] my;
    } pkt_t;

endpackage

@@ hdl/pmpd_front.sv @@
// Front end: assembles three-byte packets and classifies them.
// Depends on pmpd_pkg.
module pmpd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_byte,
    input  logic                q_full,
    output logic                q_push,
    output pmpd_pkg::pkt_t      q_pkt
);
    import pmpd_pkg::*;

    logic [1:0] pos_reg, pos_next;
    logic [7:0] hdr_reg, hdr_next;
    logic [7:0] xb_reg, xb_next;
    logic       drop_reg, drop_next;
    logic [2:0] held_reg, held_next;
    logic       acc;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;

    // Packet fields as seen on the final byte
    assign q_pkt.held = held_reg;
    assign q_pkt.newb = hdr_reg[2:0];
    assign q_pkt.mx   = {hdr_reg[HDR_X_SIGN], xb_reg};
    assign q_pkt.my   = {hdr_reg[HDR_Y_SIGN], s_in_byte};

    always_comb begin
        pos_next  = pos_reg;
        hdr_next  = hdr_reg;
        xb_next   = xb_reg;
        drop_next = drop_reg;
        held_next = held_reg;
        q_push    = 1'b0;
        if (acc) begin
            case (pos_reg)
                POS_HDR: begin
                    // drop bytes until a header with the sync bit shows up
                    if (s_in_byte[HDR_SYNC]) begin
                        hdr_next  = s_in_byte;
                        drop_next = s_in_byte[HDR_X_OVER] | s_in_byte[HDR_Y_OVER];
                        pos_next  = POS_X;
                    end
                end
                POS_X: begin
                    xb_next  = s_in_byte;
                    pos_next = POS_Y;
                end
                default: begin
                    pos_next = POS_HDR;
                    if (drop_reg) begin
                        drop_next = 1'b0;
                    end else begin
                        held_next = hdr_reg[2:0];
                        // queue only packets that produce at least one event
                        q_push = (held_reg != hdr_reg[2:0]) || (q_pkt.mx != 9'sd0)
                                 || (q_pkt.my != 9'sd0);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_HDR;
            hdr_reg  <= '0;
            xb_reg   <= '0;
            drop_reg <= 1'b0;
            held_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            hdr_reg  <= hdr_next;
            xb_reg   <= xb_next;
            drop_reg <= drop_next;
            held_reg <= held_next;
        end
    end

endmodule

@@ hdl/pmpd_queue.sv @@
// Short packet queue between front and back ends.
// Depends on pmpd_pkg.
module pmpd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pmpd_pkg::pkt_t push_pkt,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output pmpd_pkg::pkt_t head_pkt
);
    import pmpd_pkg::*;

    pkt_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, wr_next;
    logic [Q_PTR_W-1:0] rd_reg, rd_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_pkt   = slot_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("packet queue written while full");
    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("packet queue read while empty");
`endif

endmodule

@@ hdl/pmpd_back.sv @@
// Back end: expands one queued packet into button and motion events.
// Depends on pmpd_pkg.
module pmpd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  pmpd_pkg::pkt_t    head_pkt,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_event_kind,
    output logic [1:0]        m_which_button,
    output logic              m_is_pressed,
    output logic [2:0]        m_button_mask,
    output logic signed [8:0] m_move_x,
    output logic signed [8:0] m_move_y,
    output logic              m_last_of_packet
);
    import pmpd_pkg::*;

    // Work registers for the packet being expanded
    logic              busy_reg, busy_next;
    logic [2:0]        pend_reg, pend_next;
    logic [2:0]        run_reg, run_next;
    logic [2:0]        newb_reg, newb_next;
    logic              mot_reg, mot_next;
    logic signed [8:0] mx_reg, mx_next;
    logic signed [8:0] my_reg, my_next;

    // Output register
    logic              ov_reg, ov_next;
    logic              kind_reg, kind_next;
    logic [1:0]        which_reg, which_next;
    logic              press_reg, press_next;
    logic [2:0]        mask_reg, mask_next;
    logic signed [8:0] ox_reg, ox_next;
    logic signed [8:0] oy_reg, oy_next;
    logic              last_reg, last_next;

    logic emit;

    assign emit = busy_reg && (!ov_reg || m_ready);
    assign pop  = !busy_reg && head_valid;

    always_comb begin
        busy_next  = busy_reg;
        pend_next  = pend_reg;
        run_next   = run_reg;
        newb_next  = newb_reg;
        mot_next   = mot_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        ov_next    = ov_reg && !m_ready;
        kind_next  = kind_reg;
        which_next = which_reg;
        press_next = press_reg;
        mask_next  = mask_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        last_next  = last_reg;
        if (pop) begin
            busy_next = 1'b1;
            pend_next = head_pkt.held ^ head_pkt.newb;
            run_next  = head_pkt.held;
            newb_next = head_pkt.newb;
            mot_next  = (head_pkt.mx != 9'sd0) || (head_pkt.my != 9'sd0);
            mx_next   = head_pkt.mx;
            my_next   = head_pkt.my;
        end else if (emit) begin
            ov_next = 1'b1;
            ox_next = '0;
            oy_next = '0;
            kind_next = EV_BUTTON;
            // lowest pending button first: left, right, middle
            if (pend_reg[0]) begin
                which_next  = BTN_LEFT;
                press_next  = newb_reg[0];
                run_next    = {run_reg[2:1], newb_reg[0]};
                pend_next   = {pend_reg[2:1], 1'b0};
            end else if (pend_reg[1]) begin
                which_next  = BTN_RIGHT;
                press_next  = newb_reg[1];
                run_next    = {run_reg[2], newb_reg[1], run_reg[0]};
                pend_next   = {pend_reg[2], 1'b0, pend_reg[0]};
            end else if (pend_reg[2]) begin
                which_next  = BTN_MIDDLE;
                press_next  = newb_reg[2];
                run_next    = {newb_reg[2], run_reg[1:0]};
                pend_next   = 3'b000;
            end else begin
                kind_next  = EV_MOTION;
                which_next = BTN_NONE;
                press_next = 1'b0;
                ox_next    = mx_reg;
                oy_next    = my_reg;
                mot_next   = 1'b0;
            end
            mask_next = run_next;
            last_next = (pend_next == 3'b000) && !mot_next;
            busy_next = !last_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg  <= pend_next;
        run_reg   <= run_next;
        newb_reg  <= newb_next;
        mot_reg   <= mot_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        kind_reg  <= kind_next;
        which_reg <= which_next;
        press_reg <= press_next;
        mask_reg  <= mask_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    assign m_valid          = ov_reg;
    assign m_event_kind     = kind_reg;
    assign m_which_button   = which_reg;
    assign m_is_pressed     = press_reg;
    assign m_button_mask    = mask_reg;
    assign m_move_x         = ox_reg;
    assign m_move_y         = oy_reg;
    assign m_last_of_packet = last_reg;

`ifndef SYNTHESIS
    a_work_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pend_reg != 3'b000) || mot_reg)
        else $error("busy packet has no event left");
    a_stay_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !last_next) |=> busy_reg)
        else $error("packet dropped before its last event");
    a_motion_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind == EV_MOTION) |->
            (m_last_of_packet && m_which_button == BTN_NONE))
        else $error("motion event not last of packet");
`endif

endmodule

@@ hdl/ps2_mouse_packet_decoder.sv @@
// PS/2 mouse packet decoder: raw mouse bytes in, button and motion events out.
// Input channel s_*: one byte per transaction. Result channel m_*: one event per
// transaction. Three bytes make a packet (header, X low byte, Y low byte).
//
// Event path: the third byte's packet is written into the queue, loaded into the
// back end's work registers, and its first event is registered in the output
// register; later events of the same packet follow one per cycle while the
// receiver accepts them. A packet yields zero to four events; the final one
// carries m_last_of_packet. The front end takes one byte per cycle while the
// packet queue has room; the back end loads a packet in a step of its own and
// then emits its events, and takes the next packet only after the last event of
// the current one is registered.
// Headers without the sync bit are dropped; overflow packets and packets with
// no button change and no motion produce no event.
// Reset (aresetn low, synchronous): packet position, stored button state and
// the queue are cleared; no result is pending.
// Receiver stall: the output register holds its event; the back end waits, the
// two-entry queue absorbs finished packets, and s_ready falls when it is full.
// Depends on pmpd_pkg, pmpd_front, pmpd_queue, pmpd_back.
module ps2_mouse_packet_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_in_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_event_kind,
    output logic [1:0]        m_which_button,
    output logic              m_is_pressed,
    output logic [2:0]        m_button_mask,
    output logic signed [8:0] m_move_x,
    output logic signed [8:0] m_move_y,
    output logic              m_last_of_packet
);
    import pmpd_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    pkt_t push_pkt;
    pkt_t head_pkt;

    // Assemble and classify packets
    pmpd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_pkt     (push_pkt)
    );

    // Decouple packet assembly from event emission
    pmpd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_pkt   (push_pkt),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_pkt   (head_pkt)
    );

    // Expand packets into events
    pmpd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (q_valid),
        .head_pkt         (head_pkt),
        .pop              (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_which_button   (m_which_button),
        .m_is_pressed     (m_is_pressed),
        .m_button_mask    (m_button_mask),
        .m_move_x         (m_move_x),
        .m_move_y         (m_move_y),
        .m_last_of_packet (m_last_of_packet)
    );

endmodule
